// File: rtl/gas_pkg.sv
// ----------------------------------------------------------------------------
// gas_pkg
// shared types and constants of the grid path search block
// ----------------------------------------------------------------------------
package gas_pkg;

  localparam int unsigned CellBits = 8;
  localparam int unsigned Cells    = 256;
  localparam logic [15:0] Unreached = 16'hFFFF;
  localparam logic [15:0] CostCap   = 16'hFFFE;

  // item function codes
  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_SEARCH = 2'd1,
    FUNC_READ_CELL = 2'd2,
    FUNC_READ_PATH = 2'd3
  } func_e;

  // result status codes
  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusNoPath = 2'd1;
  localparam logic [1:0] StatusRange = 2'd2;

  // configuration register indexes
  localparam logic RegWidth  = 1'b0;
  localparam logic RegHeight = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_CHECK,
    ST_SCAN,
    ST_PICK,
    ST_NB_RD,
    ST_NB_UPD,
    ST_TRACE,
    ST_TRACE_RD,
    ST_COPY,
    ST_COPY_WR,
    ST_READ,
    ST_READ2,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]  status;
    logic [8:0]  path_length;
    logic [15:0] total_cost;
    logic        parent_valid;
    logic [3:0]  tile_x;
    logic [3:0]  tile_y;
  } result_t;

  typedef struct packed {
    logic [1:0] func;
    logic [3:0] pos_x;
    logic [3:0] pos_y;
    logic [3:0] goal_x;
    logic [3:0] goal_y;
    logic [7:0] move_cost;
    logic [7:0] sound_cost;
    logic       walkable;
    logic       has_goal;
    logic       use_acoustic;
    logic [7:0] path_position;
  } item_t;

  typedef struct packed {
    logic [1:0] reg_index;
    logic [4:0] data;
  } cfg_t;

endpackage

// File: rtl/gas_if.sv
// ----------------------------------------------------------------------------
// gas_if
// valid / ready channel carrying one word of a given payload type
// ----------------------------------------------------------------------------
interface gas_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/gas_ram.sv
// ----------------------------------------------------------------------------
// gas_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module gas_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: rtl/gas_core.sv
// ----------------------------------------------------------------------------
// gas_core
// sequencer with separate scan-score and relaxation add / compare logic over the cell memories
// ----------------------------------------------------------------------------
module gas_core
  import gas_pkg::*;
#(
  parameter int unsigned StepCostBits = 8
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  item_t   item_i,
  input  logic [4:0] eff_w_i,
  input  logic [4:0] eff_h_i,
  output logic    busy_o,
  output logic    done_o,
  output result_t result_o
);
  localparam int unsigned LimW = (StepCostBits > 8) ? 8 : StepCostBits;
  localparam logic [7:0] StepLim = 8'((1 << LimW) - 1);

  state_e state_q, state_d;
  item_t  it_q;
  logic [8:0] cnt_q, cnt_d;        // scan / clear counter
  logic [7:0] sel_q, sel_d;        // selected cell
  logic       found_q, found_d;
  logic [16:0] score_q, score_d;
  logic [15:0] selcost_q, selcost_d;
  logic [2:0]  nb_q, nb_d;
  logic [7:0]  nb_cell_q, nb_cell_d;
  logic        nb_ok_d;
  logic [8:0]  plen_q, plen_d;
  logic [7:0]  cur_q, cur_d;
  result_t     res_q, res_d;
  logic        goal_mode_q, goal_mode_d, acou_q, acou_d;
  logic        goal_walk_q, goal_walk_d;
  logic        searched_q, searched_d;

  // memory ports
  logic        cw_we, bw_we, pw_we, sw_we, rv_we, ps_we;
  logic [7:0]  c_raddr, b_raddr, p_raddr, s_raddr, rv_raddr, ps_raddr;
  logic [7:0]  b_waddr, p_waddr, s_waddr, rv_waddr, ps_waddr;
  logic [15:0] b_wdata, b_rdata;
  logic [8:0]  p_wdata, p_rdata;
  logic        s_wdata, s_rdata;
  logic [16:0] cell_wdata, cell_rdata;
  logic [7:0]  rv_wdata, rv_rdata, ps_wdata, ps_rdata;

  gas_ram #(.Width(17), .Depth(Cells)) u_cell (.clk_i, .we_i(cw_we),
    .waddr_i(8'({it_q.pos_y, it_q.pos_x})), .wdata_i(cell_wdata),
    .raddr_i(c_raddr), .rdata_o(cell_rdata));
  gas_ram #(.Width(16), .Depth(Cells)) u_best (.clk_i, .we_i(bw_we),
    .waddr_i(b_waddr), .wdata_i(b_wdata), .raddr_i(b_raddr), .rdata_o(b_rdata));
  gas_ram #(.Width(9), .Depth(Cells)) u_pred (.clk_i, .we_i(pw_we),
    .waddr_i(p_waddr), .wdata_i(p_wdata), .raddr_i(p_raddr), .rdata_o(p_rdata));
  gas_ram #(.Width(1), .Depth(Cells)) u_settled (.clk_i, .we_i(sw_we),
    .waddr_i(s_waddr), .wdata_i(s_wdata), .raddr_i(s_raddr), .rdata_o(s_rdata));
  gas_ram #(.Width(8), .Depth(Cells)) u_rev (.clk_i, .we_i(rv_we),
    .waddr_i(rv_waddr), .wdata_i(rv_wdata), .raddr_i(rv_raddr), .rdata_o(rv_rdata));
  gas_ram #(.Width(8), .Depth(Cells)) u_path (.clk_i, .we_i(ps_we),
    .waddr_i(ps_waddr), .wdata_i(ps_wdata), .raddr_i(ps_raddr), .rdata_o(ps_rdata));

  logic [7:0] pos_idx, goal_idx;
  logic       pos_in, goal_in;
  assign pos_idx  = {it_q.pos_y, it_q.pos_x};
  assign goal_idx = {it_q.goal_y, it_q.goal_x};
  assign pos_in   = ({1'b0, it_q.pos_x} < eff_w_i) && ({1'b0, it_q.pos_y} < eff_h_i);
  assign goal_in  = ({1'b0, it_q.goal_x} < eff_w_i) && ({1'b0, it_q.goal_y} < eff_h_i);
  assign cell_wdata = {it_q.walkable, it_q.sound_cost, it_q.move_cost};

  // scan cell of previous cycle (read data is registered behind the address)
  logic [7:0] scan_cell;
  logic       scan_in;
  logic [16:0] cand_score;
  logic [3:0]  hx, hy;
  assign scan_cell = 8'(cnt_q - 9'd1);
  assign scan_in = ({1'b0, scan_cell[3:0]} < eff_w_i) && ({1'b0, scan_cell[7:4]} < eff_h_i);
  assign hx = (scan_cell[3:0] > it_q.goal_x) ? scan_cell[3:0] - it_q.goal_x
                                            : it_q.goal_x - scan_cell[3:0];
  assign hy = (scan_cell[7:4] > it_q.goal_y) ? scan_cell[7:4] - it_q.goal_y
                                            : it_q.goal_y - scan_cell[7:4];
  assign cand_score = {1'b0, b_rdata} + (goal_mode_q ? 17'(hx) + 17'(hy) : 17'd0);

  // neighbor coordinate
  logic [4:0] nx, ny;
  always_comb begin
    nx = {1'b0, sel_q[3:0]};
    ny = {1'b0, sel_q[7:4]};
    case (nb_q[1:0])
      2'd0:    nx = nx + 5'd1;
      2'd1:    nx = nx - 5'd1;
      2'd2:    ny = ny + 5'd1;
      default: ny = ny - 5'd1;
    endcase
  end

  // adder for relaxation
  logic [7:0]  step_raw, step;
  logic [16:0] cand;
  logic [15:0] cand_sat;
  assign step_raw = acou_q ? cell_rdata[15:8] : cell_rdata[7:0];
  assign step = (step_raw > StepLim) ? StepLim : step_raw;
  assign cand = {1'b0, selcost_q} + 17'(step);
  assign cand_sat = (cand > 17'(CostCap)) ? CostCap : cand[15:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start_i) begin
        case (func_e'(item_i.func))
          FUNC_SEARCH: state_d = ST_CLEAR;
          FUNC_WRITE:  state_d = ST_READ2;
          default:     state_d = ST_READ;
        endcase
      end
      ST_CLEAR: if (cnt_q == 9'(Cells - 1)) state_d = ST_CHECK;
      ST_CHECK: begin
        if (!goal_mode_d) state_d = pos_in ? ST_SCAN : ST_OUT;
        else state_d = (pos_in && goal_in && cell_rdata[16] && goal_walk_q) ?
                       ST_SCAN : ST_OUT;
      end
      ST_SCAN: if (cnt_q == 9'(Cells)) state_d = ST_PICK;
      ST_PICK: begin
        if (!found_q) state_d = ST_OUT;
        else if (goal_mode_q && sel_q == goal_idx) state_d = ST_TRACE;
        else state_d = ST_NB_RD;
      end
      ST_NB_RD: state_d = nb_ok_d ? ST_NB_UPD : (nb_q == 3'd3 ? ST_SCAN : ST_NB_RD);
      ST_NB_UPD: state_d = (nb_q == 3'd4) ? ST_SCAN : ST_NB_RD;
      ST_TRACE: state_d = ST_TRACE_RD;
      ST_TRACE_RD: state_d = (cur_q == pos_idx || plen_q == 9'(Cells) || !p_rdata[8]) ?
                             ST_COPY : ST_TRACE_RD;
      ST_COPY: state_d = ST_COPY_WR;
      ST_COPY_WR: state_d = (cnt_q == plen_q) ? ST_OUT : ST_COPY_WR;
      ST_READ: state_d = ST_READ2;
      ST_READ2: state_d = ST_OUT;
      ST_OUT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cnt_d = cnt_q; sel_d = sel_q; found_d = found_q; score_d = score_q;
    selcost_d = selcost_q; nb_d = nb_q; nb_cell_d = nb_cell_q; nb_ok_d = 1'b0;
    plen_d = plen_q; cur_d = cur_q; res_d = res_q;
    goal_mode_d = goal_mode_q; acou_d = acou_q;
    goal_walk_d = goal_walk_q; searched_d = searched_q;
    cw_we = 1'b0; bw_we = 1'b0; pw_we = 1'b0; sw_we = 1'b0; rv_we = 1'b0; ps_we = 1'b0;
    c_raddr = pos_idx; b_raddr = cnt_q[7:0]; p_raddr = pos_idx; s_raddr = cnt_q[7:0];
    rv_raddr = cnt_q[7:0]; ps_raddr = it_q.path_position;
    b_waddr = cnt_q[7:0]; b_wdata = Unreached;
    p_waddr = cnt_q[7:0]; p_wdata = 9'd0;
    s_waddr = cnt_q[7:0]; s_wdata = 1'b0;
    rv_waddr = plen_q[7:0]; rv_wdata = cur_q;
    ps_waddr = 8'(cnt_q - 9'd1); ps_wdata = rv_rdata;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        res_d = '0;
        res_d.path_length = plen_q;
        // path tile lookup starts with the incoming word
        ps_raddr = item_i.path_position;
      end
      ST_CLEAR: begin
        bw_we = 1'b1; pw_we = 1'b1; sw_we = 1'b1;
        cnt_d = cnt_q + 9'd1;
        goal_mode_d = it_q.has_goal;
        acou_d = !it_q.has_goal && it_q.use_acoustic;
        plen_d = '0;
        searched_d = 1'b1;
        // goal cell read in the cycle before the start cell
        c_raddr = (cnt_q[7:0] == 8'd254) ? goal_idx : pos_idx;
        if (cnt_q[7:0] == 8'd255) goal_walk_d = cell_rdata[16];
      end
      ST_CHECK: begin
        // cell_rdata holds start cell, goal walkable flag was latched during clear
        goal_mode_d = goal_mode_q;
        res_d.path_length = '0;
        cnt_d = '0; found_d = 1'b0;
        if (!goal_mode_q) begin
          if (pos_in) begin
            bw_we = 1'b1; b_waddr = pos_idx; b_wdata = '0;
          end else res_d.status = StatusNoPath;
        end else if (pos_in && goal_in && cell_rdata[16] && goal_walk_q) begin
          bw_we = 1'b1; b_waddr = pos_idx; b_wdata = '0;
        end else begin
          res_d.status = StatusNoPath; res_d.total_cost = Unreached;
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + 9'd1;
        if (cnt_q != '0 && scan_in && !s_rdata && b_rdata != Unreached &&
            (!found_q || cand_score < score_q)) begin
          found_d = 1'b1; sel_d = scan_cell; score_d = cand_score; selcost_d = b_rdata;
        end
      end
      ST_PICK: begin
        nb_d = '0; cnt_d = '0;
        if (found_q && !(goal_mode_q && sel_q == goal_idx)) begin
          sw_we = 1'b1; s_waddr = sel_q; s_wdata = 1'b1;
        end
        if (found_q && goal_mode_q && sel_q == goal_idx) begin
          res_d.total_cost = selcost_q; cur_d = goal_idx; plen_d = '0;
        end
        if (!found_q && goal_mode_q) begin
          res_d.status = StatusNoPath; res_d.total_cost = Unreached;
        end
        found_d = 1'b0;
      end
      ST_NB_RD: begin
        // issue reads of the neighbor cell
        nb_ok_d = (nx < eff_w_i) && (ny < eff_h_i);
        nb_cell_d = {ny[3:0], nx[3:0]};
        c_raddr = nb_cell_d; b_raddr = nb_cell_d;
        nb_d = nb_q + 3'd1;
        if (!nb_ok_d && nb_q == 3'd3) cnt_d = '0;
      end
      ST_NB_UPD: begin
        if ((acou_q || cell_rdata[16]) && {1'b0, cand_sat} < {1'b0, b_rdata}) begin
          bw_we = 1'b1; b_waddr = nb_cell_q; b_wdata = cand_sat;
          pw_we = 1'b1; p_waddr = nb_cell_q; p_wdata = {1'b1, sel_q};
        end
        cnt_d = '0;
      end
      ST_TRACE: begin
        p_raddr = cur_q;
        rv_we = 1'b1; rv_waddr = '0; rv_wdata = cur_q; plen_d = 9'd1;
      end
      ST_TRACE_RD: begin
        p_raddr = p_rdata[7:0];
        if (!(cur_q == pos_idx || plen_q == 9'(Cells) || !p_rdata[8])) begin
          cur_d = p_rdata[7:0];
          rv_we = 1'b1; rv_waddr = plen_q[7:0]; rv_wdata = p_rdata[7:0];
          plen_d = plen_q + 9'd1;
        end
        cnt_d = '0;
      end
      ST_COPY: begin
        rv_raddr = 8'(plen_q - 9'd1);
        cnt_d = 9'd1;
      end
      ST_COPY_WR: begin
        ps_we = 1'b1;
        rv_raddr = 8'(plen_q - 9'd1 - cnt_q);
        cnt_d = cnt_q + 9'd1;
        res_d.path_length = plen_q;
      end
      ST_READ: begin
        // a path tile read fetches the best cost of the tile itself
        b_raddr = (it_q.func == FUNC_READ_PATH) ? ps_rdata : pos_idx;
        p_raddr = pos_idx; ps_raddr = it_q.path_position;
      end
      ST_READ2: begin
        if (it_q.func == FUNC_WRITE) begin
          if (!pos_in) res_d.status = StatusRange;
        end else if (it_q.func == FUNC_READ_CELL) begin
          if (pos_in) begin
            // before the first search every cell reads as unreached
            if (searched_q) begin
              res_d.total_cost = b_rdata;
              res_d.parent_valid = p_rdata[8];
              if (p_rdata[8]) begin
                res_d.tile_x = p_rdata[3:0]; res_d.tile_y = p_rdata[7:4];
              end
            end else res_d.total_cost = Unreached;
          end else res_d.status = StatusRange;
        end else if ({1'b0, it_q.path_position} < plen_q) begin
          res_d.tile_x = ps_rdata[3:0]; res_d.tile_y = ps_rdata[7:4];
          res_d.total_cost = b_rdata;
        end else res_d.status = StatusRange;
      end
      ST_OUT: begin
        if (it_q.func == FUNC_WRITE && pos_in) cw_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; plen_q <= '0; cnt_q <= '0; found_q <= 1'b0;
      nb_q <= '0; goal_mode_q <= 1'b0; acou_q <= 1'b0; searched_q <= 1'b0;
    end else begin
      state_q <= state_d; plen_q <= plen_d; cnt_q <= cnt_d; found_q <= found_d;
      nb_q <= nb_d; goal_mode_q <= goal_mode_d; acou_q <= acou_d; searched_q <= searched_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) it_q <= item_i;
    sel_q <= sel_d; score_q <= score_d; selcost_q <= selcost_d;
    nb_cell_q <= nb_cell_d; cur_q <= cur_d; res_q <= res_d; goal_walk_q <= goal_walk_d;
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_OUT);
  always_comb begin
    result_o = res_q;
    result_o.path_length = plen_q;
  end
endmodule

// File: rtl/grid_astar_dijkstra_search.sv
// a write runs READ2 and OUT, a read READ, READ2 and OUT, before the result word is valid
// search: a clear of all cells and a start check, then per pick a scan of all open scores,
// then neighbor reads and in-grid updates, and on a found path a trace and copy per tile
// throughput: one word at a time; a new word is taken the cycle after the result leaves
// reset: asynchronous active low; grid size returns to 16 x 16, path length 0, best costs
// read as unreached until the first search; cell costs are undefined until written
module grid_astar_dijkstra_search
  import gas_pkg::*;
#(
  parameter int unsigned MAX_WIDTH      = 16,
  parameter int unsigned MAX_HEIGHT     = 16,
  parameter int unsigned STEP_COST_BITS = 8
) (
  input logic clk_i,
  input logic rst_ni,
  gas_if.sink   cfg_i,
  gas_if.sink   in_i,
  gas_if.source out_o
);
  localparam logic [4:0] CapW = 5'((MAX_WIDTH < 16) ? MAX_WIDTH : 16);
  localparam logic [4:0] CapH = 5'((MAX_HEIGHT < 16) ? MAX_HEIGHT : 16);

  logic [4:0] width_q, height_q, eff_w, eff_h;
  logic       busy, done, out_valid_q;
  result_t    res, out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 5'd16; height_q <= 5'd16;
    end else if (cfg_i.valid) begin
      if (cfg_i.data.reg_index == {1'b0, RegWidth}) width_q <= cfg_i.data.data;
      if (cfg_i.data.reg_index == {1'b0, RegHeight}) height_q <= cfg_i.data.data;
    end
  end
  assign cfg_i.ready = 1'b1;
  assign eff_w = (width_q == 5'd0) ? 5'd1 : ((width_q > CapW) ? CapW : width_q);
  assign eff_h = (height_q == 5'd0) ? 5'd1 : ((height_q > CapH) ? CapH : height_q);

  assign in_i.ready = !busy && !out_valid_q;

  gas_core #(.StepCostBits(STEP_COST_BITS)) u_core (
    .clk_i, .rst_ni, .start_i(in_i.valid && in_i.ready), .item_i(in_i.data),
    .eff_w_i(eff_w), .eff_h_i(eff_h), .busy_o(busy), .done_o(done), .result_o(res));

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (done) out_valid_q <= 1'b1;
    else if (out_o.ready) out_valid_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (done) out_q <= res;
  end
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;
endmodule

// File: rtl/gas_checker.sv
// ----------------------------------------------------------------------------
// gas_checker
// port level checks of the grid path search block
// ----------------------------------------------------------------------------
module gas_checker
  import gas_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid_i,
  input logic    in_ready_i,
  input logic    out_valid_i,
  input logic    out_ready_i,
  input result_t out_data_i
);
  // no new word while a result waits
  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i) else $error("word taken while result pending");
  // a result never appears the cycle after a take
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !out_valid_i) else $error("result too early");
  // status code in range
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.status != 2'd3) else $error("bad status");
  // held result stays stable
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i)) else $error("result changed");
endmodule

bind grid_astar_dijkstra_search gas_checker u_gas_checker (
  .clk_i, .rst_ni, .in_valid_i(in_i.valid), .in_ready_i(in_i.ready),
  .out_valid_i(out_o.valid), .out_ready_i(out_o.ready), .out_data_i(out_o.data));

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench of the grid path search block: a cycle-free predictor
// mirrors cell tables, search tables and stored path, and every result word
// is compared field by field against it, partly under random idling on both sides
// ----------------------------------------------------------------------------
module tb_top;
  import gas_pkg::*;

  localparam int unsigned WatchLimit = 300000;
  localparam int unsigned NoCell     = 256;

  logic clk_i;
  logic rst_ni;

  gas_if #(.payload_t(cfg_t))    cfg_if ();
  gas_if #(.payload_t(item_t))   in_if ();
  gas_if #(.payload_t(result_t)) out_if ();

  grid_astar_dijkstra_search dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // predicted block state
  logic [7:0]  mirror_move [NoCell];
  logic [7:0]  mirror_sound [NoCell];
  logic        mirror_walk [NoCell];
  logic [15:0] mirror_best [NoCell];
  logic [8:0]  mirror_pred [NoCell];
  logic        mirror_done [NoCell];
  logic [7:0]  mirror_path [NoCell];
  int unsigned mirror_plen;
  int unsigned width_reg;
  int unsigned height_reg;

  result_t     pending_results[$];
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int unsigned rx_hold;
  int unsigned fail_count;
  int unsigned words_sent;
  int unsigned searches_sent;
  int unsigned results_seen;
  int unsigned idle_cycles;

  // clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic int unsigned eff_dim(int unsigned r);
    if (r == 0) return 1;
    return (r > 16) ? 16 : r;
  endfunction

  function automatic int unsigned absdiff(int unsigned a, int unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  // lowest-score expansion over the active grid
  function automatic void expand_grid(int unsigned w, int unsigned h, int unsigned start,
                                      int unsigned goal, bit with_goal, bit acoustic);
    int dx[4];
    int dy[4];
    int unsigned sel;
    int unsigned sel_score;
    int unsigned score;
    int unsigned cand;
    int unsigned step;
    int unsigned n;
    int nx;
    int ny;
    dx = '{1, -1, 0, 0};
    dy = '{0, 0, 1, -1};
    mirror_best[start] = 16'd0;
    while (1) begin
      sel = NoCell;
      sel_score = 0;
      for (int unsigned i = 0; i < NoCell; i++) begin
        if ((i % 16) >= w || (i / 16) >= h || mirror_done[i] || mirror_best[i] == Unreached)
          continue;
        score = mirror_best[i];
        if (with_goal) score += absdiff(i % 16, goal % 16) + absdiff(i / 16, goal / 16);
        if (sel == NoCell || score < sel_score) begin
          sel = i;
          sel_score = score;
        end
      end
      if (sel == NoCell) break;
      if (with_goal && sel == goal) break;
      mirror_done[sel] = 1'b1;
      for (int k = 0; k < 4; k++) begin
        nx = int'(sel % 16) + dx[k];
        ny = int'(sel / 16) + dy[k];
        if (nx < 0 || ny < 0 || nx >= int'(w) || ny >= int'(h)) continue;
        n = ny * 16 + nx;
        if (!acoustic && !mirror_walk[n]) continue;
        step = acoustic ? mirror_sound[n] : mirror_move[n];
        cand = mirror_best[sel] + step;
        if (cand > CostCap) cand = CostCap;
        if (cand < mirror_best[n]) begin
          mirror_best[n] = cand[15:0];
          mirror_pred[n] = {1'b1, sel[7:0]};
        end
      end
    end
  endfunction

  // expected result of one word, updating the mirrored state
  function automatic result_t predict_result(item_t it);
    result_t r;
    int unsigned w;
    int unsigned h;
    int unsigned pos;
    int unsigned goal;
    int unsigned cur;
    int unsigned n;
    int unsigned t;
    bit pos_in;
    bit ok;
    bit acoustic;
    int unsigned trail [NoCell];
    r = '0;
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    pos = it.pos_y * 16 + it.pos_x;
    goal = it.goal_y * 16 + it.goal_x;
    pos_in = (it.pos_x < w) && (it.pos_y < h);
    case (func_e'(it.func))
      FUNC_WRITE: begin
        if (pos_in) begin
          mirror_move[pos] = it.move_cost;
          mirror_sound[pos] = it.sound_cost;
          mirror_walk[pos] = it.walkable;
        end else begin
          r.status = StatusRange;
        end
      end
      FUNC_SEARCH: begin
        acoustic = !it.has_goal && it.use_acoustic;
        for (int unsigned i = 0; i < NoCell; i++) begin
          mirror_best[i] = Unreached;
          mirror_pred[i] = '0;
          mirror_done[i] = 1'b0;
        end
        mirror_plen = 0;
        if (it.has_goal) begin
          ok = pos_in && it.goal_x < w && it.goal_y < h && mirror_walk[pos] && mirror_walk[goal];
          if (ok) begin
            expand_grid(w, h, pos, goal, 1'b1, 1'b0);
            ok = (goal == pos) || mirror_pred[goal][8];
          end
          if (ok) begin
            n = 0;
            cur = goal;
            while (1) begin
              trail[n] = cur;
              n++;
              if (cur == pos || n >= NoCell || !mirror_pred[cur][8]) break;
              cur = mirror_pred[cur][7:0];
            end
            for (int unsigned i = 0; i < n; i++) mirror_path[i] = trail[n - 1 - i][7:0];
            mirror_plen = n;
            r.total_cost = mirror_best[goal];
          end else begin
            r.status = StatusNoPath;
            r.total_cost = Unreached;
          end
        end else if (pos_in) begin
          expand_grid(w, h, pos, 0, 1'b0, acoustic);
        end else begin
          r.status = StatusNoPath;
        end
      end
      FUNC_READ_CELL: begin
        if (pos_in) begin
          r.total_cost = mirror_best[pos];
          if (mirror_pred[pos][8]) begin
            r.parent_valid = 1'b1;
            r.tile_x = mirror_pred[pos][3:0];
            r.tile_y = mirror_pred[pos][7:4];
          end
        end else begin
          r.status = StatusRange;
        end
      end
      default: begin
        if (it.path_position < mirror_plen) begin
          t = mirror_path[it.path_position];
          r.tile_x = t[3:0];
          r.tile_y = t[7:4];
          r.total_cost = mirror_best[t];
        end else begin
          r.status = StatusRange;
        end
      end
    endcase
    r.path_length = mirror_plen[8:0];
    return r;
  endfunction

  // send one word, idling before it as the current mode asks
  task automatic send_word(input item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= it;
    do @(posedge clk_i); while (!in_if.ready);
    pending_results = {pending_results, predict_result(it)};
    words_sent++;
    if (func_e'(it.func) == FUNC_SEARCH) searches_sent++;
  endtask

  task automatic wait_drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // register write, only with the block idle
  task automatic write_reg(input logic idx, input int unsigned val);
    wait_drain();
    cfg_if.valid <= 1'b1;
    cfg_if.data <= '{reg_index: {1'b0, idx}, data: val[4:0]};
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == RegWidth) width_reg = val[4:0];
    else height_reg = val[4:0];
  endtask

  task automatic set_grid(input int unsigned w, input int unsigned h);
    write_reg(RegWidth, w);
    write_reg(RegHeight, h);
  endtask

  function automatic item_t rand_word(func_e f);
    item_t it;
    it = item_t'($bits(item_t)'({$urandom, $urandom}));
    it.func = f;
    return it;
  endfunction

  function automatic item_t cell_word(func_e f, int unsigned x, int unsigned y);
    item_t it;
    it = rand_word(f);
    it.pos_x = x[3:0];
    it.pos_y = y[3:0];
    return it;
  endfunction

  task automatic write_cell(input int unsigned x, input int unsigned y, input int unsigned mv,
                            input int unsigned sd, input bit walk);
    item_t it;
    it = cell_word(FUNC_WRITE, x, y);
    it.move_cost = mv[7:0];
    it.sound_cost = sd[7:0];
    it.walkable = walk;
    send_word(it);
  endtask

  task automatic search(input int unsigned sx, input int unsigned sy, input int unsigned gx,
                        input int unsigned gy, input bit goal_on, input bit acoustic);
    item_t it;
    it = cell_word(FUNC_SEARCH, sx, sy);
    it.goal_x = gx[3:0];
    it.goal_y = gy[3:0];
    it.has_goal = goal_on;
    it.use_acoustic = acoustic;
    send_word(it);
  endtask

  task automatic read_tile(input int unsigned k);
    item_t it;
    it = rand_word(FUNC_READ_PATH);
    it.path_position = k[7:0];
    send_word(it);
  endtask

  // random word shaped toward deep searches on the active grid
  function automatic item_t shaped_word();
    item_t it;
    int unsigned w;
    int unsigned h;
    int unsigned pick;
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    pick = $urandom_range(99);
    it = rand_word(FUNC_READ_CELL);
    if ($urandom_range(9) != 0) begin
      it.pos_x = 4'($urandom_range(w - 1));
      it.pos_y = 4'($urandom_range(h - 1));
      it.goal_x = 4'($urandom_range(w - 1));
      it.goal_y = 4'($urandom_range(h - 1));
    end
    if (pick < 30) begin
      it.func = FUNC_WRITE;
      it.walkable = ($urandom_range(99) < 80);
      if ($urandom_range(7) == 0) it.move_cost = $urandom_range(1) ? 8'hFF : 8'h00;
    end else if (pick < ((w * h > 64) ? 31 : 39)) begin
      it.func = FUNC_SEARCH;
      it.has_goal = ($urandom_range(99) < 70);
    end else if (pick < 70) begin
      it.func = FUNC_READ_CELL;
    end else begin
      it.func = FUNC_READ_PATH;
      if ($urandom_range(3) != 0) it.path_position = 8'($urandom_range(mirror_plen + 1));
    end
    return it;
  endfunction

  // receiver ready, with a long hold-off on request
  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      out_if.ready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // result checking
  always @(posedge clk_i) begin
    result_t e;
    result_t a;
    if (rst_ni && out_if.valid && out_if.ready) begin
      a = out_if.data;
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        if (a.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, a.status);
          fail_count++;
        end
        if (a.path_length !== e.path_length) begin
          $error("path_length expected %0d actual %0d", e.path_length, a.path_length);
          fail_count++;
        end
        if (a.total_cost !== e.total_cost) begin
          $error("total_cost expected %0d actual %0d", e.total_cost, a.total_cost);
          fail_count++;
        end
        if (a.parent_valid !== e.parent_valid) begin
          $error("parent_valid expected %0d actual %0d", e.parent_valid, a.parent_valid);
          fail_count++;
        end
        if (a.tile_x !== e.tile_x) begin
          $error("tile_x expected %0d actual %0d", e.tile_x, a.tile_x);
          fail_count++;
        end
        if (a.tile_y !== e.tile_y) begin
          $error("tile_y expected %0d actual %0d", e.tile_y, a.tile_y);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchLimit) begin
      $display("grid_astar_dijkstra_search test failed");
      $finish;
    end
  end

  // state after reset, before any search
  task automatic test_reset_state();
    send_word(cell_word(FUNC_READ_CELL, 15, 15));
    read_tile(0);
  endtask

  // every cell of the full grid gets written once
  task automatic test_load_grid();
    for (int unsigned y = 0; y < 16; y++) begin
      for (int unsigned x = 0; x < 16; x++) begin
        write_cell(x, y, $urandom_range(255), $urandom_range(255), ($urandom_range(9) != 0));
      end
    end
  endtask

  // extremes, rejections and each search kind on a small grid
  task automatic test_directed();
    set_grid(4, 4);
    write_cell(0, 0, 0, 255, 1'b1);
    write_cell(1, 0, 255, 0, 1'b1);
    write_cell(3, 3, 255, 255, 1'b1);
    write_cell(5, 5, 7, 7, 1'b1);
    write_cell(15, 15, 7, 7, 1'b1);
    search(0, 0, 0, 0, 1'b1, 1'b0);
    read_tile(0);
    search(0, 0, 3, 3, 1'b1, 1'b0);
    read_tile(0);
    read_tile(1);
    read_tile(255);
    send_word(cell_word(FUNC_READ_CELL, 3, 3));
    send_word(cell_word(FUNC_READ_CELL, 9, 9));
    search(7, 0, 3, 3, 1'b1, 1'b0);
    search(0, 0, 3, 9, 1'b1, 1'b0);
    write_cell(3, 3, 1, 1, 1'b0);
    search(0, 0, 3, 3, 1'b1, 1'b0);
    search(3, 3, 0, 0, 1'b0, 1'b0);
    send_word(cell_word(FUNC_READ_CELL, 0, 0));
    search(2, 1, 0, 0, 1'b0, 1'b1);
    send_word(cell_word(FUNC_READ_CELL, 3, 3));
    search(4, 0, 0, 0, 1'b0, 1'b1);
  endtask

  // grid size extremes, with saturation and zero
  task automatic test_grid_sizes();
    set_grid(0, 31);
    search(0, 0, 0, 0, 1'b0, 1'b1);
    send_word(cell_word(FUNC_READ_CELL, 0, 15));
    set_grid(17, 0);
    search(0, 0, 15, 0, 1'b1, 1'b0);
    read_tile(15);
    set_grid(16, 16);
    search(15, 15, 0, 0, 1'b0, 1'b0);
    send_word(cell_word(FUNC_READ_CELL, 0, 0));
    set_grid(1, 1);
    write_cell(1, 0, 3, 3, 1'b1);
    search(0, 0, 0, 0, 1'b1, 1'b0);
  endtask

  // random words across grid sizes and idle modes
  task automatic test_random();
    int unsigned pct_tx [4];
    int unsigned pct_rx [4];
    pct_tx = '{0, 86, 0, 34};
    pct_rx = '{0, 0, 86, 34};
    for (int p = 0; p < 8; p++) begin
      set_grid($urandom_range(2, 6), $urandom_range(1, 6));
      tx_idle_pct = pct_tx[p % 4];
      rx_stall_pct = pct_rx[p % 4];
      repeat (150) send_word(shaped_word());
    end
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    set_grid(16, 16);
    repeat (60) send_word(shaped_word());
  endtask

  // long receiver hold-off with the sender still offering, then a full drain
  task automatic test_backpressure();
    set_grid(5, 5);
    wait_drain();
    rx_hold = 400;
    repeat (20) send_word(shaped_word());
    wait_drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    rx_hold = 0;
    fail_count = 0;
    words_sent = 0;
    searches_sent = 0;
    results_seen = 0;
    idle_cycles = 0;
    width_reg = 16;
    height_reg = 16;
    mirror_plen = 0;
    for (int unsigned i = 0; i < NoCell; i++) begin
      mirror_move[i] = '0;
      mirror_sound[i] = '0;
      mirror_walk[i] = 1'b0;
      mirror_best[i] = Unreached;
      mirror_pred[i] = '0;
      mirror_done[i] = 1'b0;
      mirror_path[i] = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_load_grid();
    test_directed();
    test_grid_sizes();
    test_backpressure();
    test_random();
    wait_drain();
    repeat (20) @(posedge clk_i);
    $display("covered %0d words, %0d of them searches, %0d results checked",
             words_sent, searches_sent, results_seen);
    $display("grid sizes from 1x1 to 16x16 with saturated registers, all idle modes");
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("grid_astar_dijkstra_search test passed");
    end else begin
      $display("grid_astar_dijkstra_search test failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/gas_pkg.sv
rtl/gas_if.sv
rtl/gas_ram.sv
rtl/gas_core.sv
rtl/grid_astar_dijkstra_search.sv
rtl/gas_checker.sv
tb/tb_top.sv
